// ===== hw/rtl/mwld_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the magic word deframer
package mwld_pkg;

	localparam int BYTE_W     = 8;
	localparam int WORD_W     = 32;
	localparam int META_REG_W = 16;
	localparam int TYPE_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int FILL_W     = 3;
	localparam int HDR_CNT_W  = 4;

	// upper three bytes of the magic word, low byte is the frame type
	localparam logic [23:0]        MAGIC_BASE       = 24'hA5B601;
	localparam logic [BYTE_W-1:0]  MAGIC_TYPES      = 8'd5;
	localparam logic [WORD_W-1:0]  DEFAULT_MAX_DATA = 32'd536870912;
	localparam logic [FILL_W-1:0]  WINDOW_FULL      = 3'd4;
	localparam logic [HDR_CNT_W-1:0] HDR_START      = 4'd4;
	localparam logic [HDR_CNT_W-1:0] HDR_META_END   = 4'd8;
	localparam logic [HDR_CNT_W-1:0] HDR_LAST_SHORT = 4'd7;
	localparam logic [HDR_CNT_W-1:0] HDR_LAST_LONG  = 4'd11;

	localparam logic [TYPE_W-1:0] TYPE_PLAIN      = 3'd0;
	localparam logic [TYPE_W-1:0] TYPE_AUDIO      = 3'd1;
	localparam logic [TYPE_W-1:0] TYPE_VIDEO      = 3'd2;
	localparam logic [TYPE_W-1:0] TYPE_SUBTITLE   = 3'd3;
	localparam logic [TYPE_W-1:0] TYPE_SUBPICTURE = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DATA    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_META_AUDIO  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_META_VIDEO  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_META_SUBTTL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_META_SUBPIC = 3'd4;

	typedef enum logic [1:0] {
		KIND_META   = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_EMPTY  = 2'd2,
		KIND_REJECT = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		PH_HUNT = 4'b0001,
		PH_HEAD = 4'b0010,
		PH_META = 4'b0100,
		PH_DATA = 4'b1000
	} phase_t;

endpackage

// ===== hw/rtl/magic_word_length_deframer_core.sv =====
`timescale 1ns / 1ps
// magic word hunting, length-prefixed frame deframer, one byte per cycle
//
// channel | signals                              | direction
// --------+--------------------------------------+----------
// input   | in_valid in_ready in_byte            | in
// output  | out_valid out_ready out_byte out_kind| out
//         | frame_type frame_last                |
// config  | cfg_we cfg_index cfg_data            | in
//
// one byte per cycle while not stalled; each result shows in the cycle after
// its byte is taken; the frame state update and the 32-bit length compare sit
// between the state registers and the result register
// in_ready drops only while a result waits and out_ready is low
// reset restores register defaults and restarts the hunt with an empty window
module magic_word_length_deframer_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [mwld_pkg::BYTE_W-1:0]        in_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [mwld_pkg::BYTE_W-1:0]        out_byte,
	output mwld_pkg::kind_t                    out_kind,
	output logic [mwld_pkg::TYPE_W-1:0]        frame_type,
	output logic                               frame_last,
	input  logic                               cfg_we,
	input  logic [mwld_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mwld_pkg::WORD_W-1:0]        cfg_data
);
	import mwld_pkg::*;

	logic [WORD_W-1:0]     max_data_q;
	logic [META_REG_W-1:0] meta_audio_q, meta_video_q, meta_subttl_q, meta_subpic_q;

	phase_t                phase_q, phase_d;
	logic [WORD_W-1:0]     window_q, window_d;
	logic [FILL_W-1:0]     fill_q, fill_d;
	logic [TYPE_W-1:0]     type_q, type_d;
	logic [HDR_CNT_W-1:0]  hdr_cnt_q, hdr_cnt_d;
	logic [WORD_W-1:0]     meta_len_q, meta_len_d;
	logic [WORD_W-1:0]     data_len_q, data_len_d;
	logic [WORD_W-1:0]     remain_q, remain_d;

	logic                  out_valid_q;
	logic [BYTE_W-1:0]     out_byte_q;
	kind_t                 out_kind_q;
	logic [TYPE_W-1:0]     out_type_q;
	logic                  out_last_q;

	logic                  res_valid;
	logic [BYTE_W-1:0]     res_byte;
	kind_t                 res_kind;
	logic                  res_last;

	logic                  in_fire;
	logic [WORD_W-1:0]     lane_word;
	logic [WORD_W-1:0]     req_meta;
	logic                  hdr_is_meta;
	logic                  hdr_done;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_data_q    <= DEFAULT_MAX_DATA;
			meta_audio_q  <= '0;
			meta_video_q  <= '0;
			meta_subttl_q <= '0;
			meta_subpic_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MAX_DATA)    max_data_q    <= cfg_data;
			if (cfg_index == CFG_META_AUDIO)  meta_audio_q  <= cfg_data[META_REG_W-1:0];
			if (cfg_index == CFG_META_VIDEO)  meta_video_q  <= cfg_data[META_REG_W-1:0];
			if (cfg_index == CFG_META_SUBTTL) meta_subttl_q <= cfg_data[META_REG_W-1:0];
			if (cfg_index == CFG_META_SUBPIC) meta_subpic_q <= cfg_data[META_REG_W-1:0];
		end
	end

	always_comb begin
		unique case (type_q)
			TYPE_AUDIO:      req_meta = {{(WORD_W-META_REG_W){1'b0}}, meta_audio_q};
			TYPE_VIDEO:      req_meta = {{(WORD_W-META_REG_W){1'b0}}, meta_video_q};
			TYPE_SUBTITLE:   req_meta = {{(WORD_W-META_REG_W){1'b0}}, meta_subttl_q};
			TYPE_SUBPICTURE: req_meta = {{(WORD_W-META_REG_W){1'b0}}, meta_subpic_q};
			default:         req_meta = '0;
		endcase
	end

	assign hdr_is_meta = (type_q != TYPE_PLAIN) && (hdr_cnt_q < HDR_META_END);
	assign hdr_done    = (type_q == TYPE_PLAIN) ? (hdr_cnt_q == HDR_LAST_SHORT)
	                                            : (hdr_cnt_q == HDR_LAST_LONG);

	// drop the incoming byte into its lane of the length field being assembled
	always_comb begin
		lane_word = hdr_is_meta ? meta_len_q : data_len_q;
		for (int i = 0; i < 4; i++) begin
			if (hdr_cnt_q[1:0] == 2'(i)) lane_word[BYTE_W*i +: BYTE_W] = in_byte;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		window_d   = window_q;
		fill_d     = fill_q;
		type_d     = type_q;
		hdr_cnt_d  = hdr_cnt_q;
		meta_len_d = meta_len_q;
		data_len_d = data_len_q;
		remain_d   = remain_q;
		res_valid  = 1'b0;
		res_byte   = '0;
		res_kind   = KIND_META;
		res_last   = 1'b0;

		unique case (phase_q)
			PH_HUNT: begin
				window_d = {in_byte, window_q[WORD_W-1:BYTE_W]};
				if (fill_q < WINDOW_FULL) fill_d = fill_q + 1'b1;
				if (fill_d == WINDOW_FULL && window_d[WORD_W-1:BYTE_W] == MAGIC_BASE &&
				    window_d[BYTE_W-1:0] < MAGIC_TYPES) begin
					type_d     = window_d[TYPE_W-1:0];
					phase_d    = PH_HEAD;
					hdr_cnt_d  = HDR_START;
					meta_len_d = '0;
					data_len_d = '0;
				end
			end
			PH_HEAD: begin
				if (hdr_is_meta) meta_len_d = lane_word;
				else             data_len_d = lane_word;
				hdr_cnt_d = hdr_cnt_q + 1'b1;
				if (hdr_done) begin
					if (type_q == TYPE_PLAIN) meta_len_d = '0;
					priority if (data_len_d > max_data_q ||
					             (type_q != TYPE_PLAIN && meta_len_d != req_meta)) begin
						res_valid = 1'b1;
						res_kind  = KIND_REJECT;
						res_last  = 1'b1;
						phase_d   = PH_HUNT;
					end else if (meta_len_d == '0 && data_len_d == '0) begin
						res_valid = 1'b1;
						res_kind  = KIND_EMPTY;
						res_last  = 1'b1;
						phase_d   = PH_HUNT;
					end else if (meta_len_d != '0) begin
						phase_d  = PH_META;
						remain_d = meta_len_d;
					end else begin
						phase_d  = PH_DATA;
						remain_d = data_len_d;
					end
				end
			end
			PH_META: begin
				res_valid = 1'b1;
				res_byte  = in_byte;
				res_kind  = KIND_META;
				remain_d  = remain_q - 1'b1;
				if (remain_d == '0) begin
					if (data_len_q == '0) begin
						res_last = 1'b1;
						phase_d  = PH_HUNT;
					end else begin
						phase_d  = PH_DATA;
						remain_d = data_len_q;
					end
				end
			end
			PH_DATA: begin
				res_valid = 1'b1;
				res_byte  = in_byte;
				res_kind  = KIND_DATA;
				remain_d  = remain_q - 1'b1;
				if (remain_d == '0) begin
					res_last = 1'b1;
					phase_d  = PH_HUNT;
				end
			end
			default: phase_d = PH_HUNT;
		endcase

		// leaving a frame starts a fresh hunt, header bytes are not rescanned
		if (phase_q != PH_HUNT && phase_d == PH_HUNT) begin
			window_d  = '0;
			fill_d    = '0;
			hdr_cnt_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			window_q   <= '0;
			fill_q     <= '0;
			type_q     <= '0;
			hdr_cnt_q  <= '0;
			meta_len_q <= '0;
			data_len_q <= '0;
			remain_q   <= '0;
		end else if (in_fire) begin
			phase_q    <= phase_d;
			window_q   <= window_d;
			fill_q     <= fill_d;
			type_q     <= type_d;
			hdr_cnt_q  <= hdr_cnt_d;
			meta_len_q <= meta_len_d;
			data_len_q <= data_len_d;
			remain_q   <= remain_d;
		end
	end

	// result register, refilled in the cycle the waiting transaction leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && res_valid) begin
			out_byte_q <= res_byte;
			out_kind_q <= res_kind;
			out_type_q <= type_q;
			out_last_q <= res_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign out_kind   = out_kind_q;
	assign frame_type = out_type_q;
	assign frame_last = out_last_q;

	a_hunt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && phase_q == PH_HUNT |=> !out_valid_q)
		else $error("result produced while hunting");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |-> phase_q == PH_HUNT && fill_q == '0)
		else $error("final result without a fresh hunt");

	a_marker_format: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_kind_q == KIND_EMPTY || out_kind_q == KIND_REJECT)
		|-> out_last_q && out_byte_q == '0)
		else $error("empty or reject marker malformed");

	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid_q && !out_ready)
		else $error("input stalled with free result register");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the magic word length deframer core
module tb_top;
	import mwld_pkg::*;

	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int DRAIN_CYCLES = 4;
	localparam int RANDOM_BYTES = 500;
	localparam int RESET_CYCLES = 3;
	localparam int LONG_HOLD    = 400;
	localparam int LONG_META    = 200;
	// breaks any partial magic word left in the hunting window
	localparam logic [BYTE_W-1:0] FILLER_BYTE = 8'h11;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		kind_t             kind;
		logic [TYPE_W-1:0] ftype;
		logic              last;
	} frame_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [BYTE_W-1:0]     in_byte = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [BYTE_W-1:0]     out_byte;
	kind_t                 out_kind;
	logic [TYPE_W-1:0]     frame_type;
	logic                  frame_last;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [WORD_W-1:0]     cfg_data = '0;

	// deframer state as tracked by the bench
	phase_t                pr_phase = PH_HUNT;
	logic [WORD_W-1:0]     pr_window = '0;
	int                    pr_fill = 0;
	logic [TYPE_W-1:0]     pr_type = '0;
	int                    pr_hdr_cnt = 0;
	logic [WORD_W-1:0]     pr_meta = '0;
	logic [WORD_W-1:0]     pr_data = '0;
	logic [WORD_W-1:0]     pr_left = '0;

	// register copies, indexed by frame type for the metadata lengths
	logic [WORD_W-1:0]     cfg_max = DEFAULT_MAX_DATA;
	logic [META_REG_W-1:0] req_meta [5] = '{default: '0};

	frame_result_t         frame_outputs_due [$];
	int                    error_count = 0;
	int                    bytes_sent = 0;
	int                    cycle_count = 0;
	bit                    send_quiet = 1'b0;
	bit                    recv_quiet = 1'b0;
	int                    stall_request = 0;
	bit                    holding = 1'b0;

	magic_word_length_deframer_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_kind   (out_kind),
		.frame_type (frame_type),
		.frame_last (frame_last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("magic_word_length_deframer_core: mismatch");
			$finish;
		end
	end

	task automatic report_error(input string what, input logic [31:0] want,
		input logic [31:0] got);
		$display("%0t ns: %s: expected %0h, got %0h", $realtime, what, want, got);
		error_count++;
	endtask

	function automatic logic [WORD_W-1:0] meta_required(input logic [TYPE_W-1:0] t);
		if (t == TYPE_PLAIN || t > TYPE_SUBPICTURE)
			return '0;
		return {{(WORD_W-META_REG_W){1'b0}}, req_meta[t]};
	endfunction

	task automatic restart_hunt();
		pr_phase   = PH_HUNT;
		pr_window  = '0;
		pr_fill    = 0;
		pr_hdr_cnt = 0;
	endtask

	task automatic push_result(input logic [BYTE_W-1:0] b, input kind_t k, input logic last);
		frame_result_t r;
		r.data  = b;
		r.kind  = k;
		r.ftype = pr_type;
		r.last  = last;
		frame_outputs_due.push_back(r);
	endtask

	// advances the tracked deframer by one accepted stream byte
	task automatic deframe_byte(input logic [BYTE_W-1:0] b);
		int   total;
		int   pos;
		int   sh;
		logic last;
		case (pr_phase)
			PH_HUNT: begin
				pr_window = {b, pr_window[WORD_W-1:BYTE_W]};
				if (pr_fill < WINDOW_FULL)
					pr_fill++;
				if (pr_fill == WINDOW_FULL && pr_window[WORD_W-1:BYTE_W] == MAGIC_BASE &&
					pr_window[BYTE_W-1:0] < MAGIC_TYPES) begin
					pr_type    = pr_window[TYPE_W-1:0];
					pr_phase   = PH_HEAD;
					pr_hdr_cnt = HDR_START;
					pr_meta    = '0;
					pr_data    = '0;
				end
			end
			PH_HEAD: begin
				total = (pr_type == TYPE_PLAIN) ? HDR_META_END : HDR_LAST_LONG + 1;
				pos = pr_hdr_cnt;
				sh = (pos & 3) * BYTE_W;
				if (pr_type != TYPE_PLAIN && pos < HDR_META_END)
					pr_meta[sh +: BYTE_W] = b;
				else
					pr_data[sh +: BYTE_W] = b;
				pr_hdr_cnt = pos + 1;
				if (pr_hdr_cnt == total) begin
					if (pr_type == TYPE_PLAIN)
						pr_meta = '0;
					// the data length is checked ahead of the metadata length
					if (pr_data > cfg_max ||
						(pr_type != TYPE_PLAIN && pr_meta != meta_required(pr_type))) begin
						push_result('0, KIND_REJECT, 1'b1);
						restart_hunt();
					end else if (pr_meta == 0 && pr_data == 0) begin
						push_result('0, KIND_EMPTY, 1'b1);
						restart_hunt();
					end else if (pr_meta != 0) begin
						pr_phase = PH_META;
						pr_left  = pr_meta;
					end else begin
						pr_phase = PH_DATA;
						pr_left  = pr_data;
					end
				end
			end
			PH_META: begin
				last = 1'b0;
				pr_left = pr_left - 1;
				if (pr_left == 0) begin
					if (pr_data == 0) begin
						last = 1'b1;
						restart_hunt();
					end else begin
						pr_phase = PH_DATA;
						pr_left  = pr_data;
					end
				end
				push_result(b, KIND_META, last);
			end
			PH_DATA: begin
				last = 1'b0;
				pr_left = pr_left - 1;
				if (pr_left == 0) begin
					last = 1'b1;
					restart_hunt();
				end
				push_result(b, KIND_DATA, last);
			end
			default: begin
				restart_hunt();
			end
		endcase
	endtask

	function automatic int send_gap();
		int r;
		if (send_quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = send_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (!in_ready);
		deframe_byte(b);
		bytes_sent++;
	endtask

	task automatic send_word(input logic [WORD_W-1:0] w);
		for (int i = 0; i < WORD_W / BYTE_W; i++)
			send_byte(w[i*BYTE_W +: BYTE_W]);
	endtask

	function automatic logic [BYTE_W-1:0] pick_payload_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return '1;
		if (r < 25)
			return MAGIC_BASE[23:16];
		return BYTE_W'($urandom);
	endfunction

	// header as given, then payload for as long as the deframer expects it
	task automatic send_frame(input logic [TYPE_W-1:0] t, input logic [WORD_W-1:0] meta,
		input logic [WORD_W-1:0] len);
		send_word({MAGIC_BASE, BYTE_W'(t)});
		if (t != TYPE_PLAIN)
			send_word(meta);
		send_word(len);
		while (pr_phase == PH_META || pr_phase == PH_DATA)
			send_byte(pick_payload_byte());
	endtask

	task automatic send_partial_magic(input int count);
		logic [WORD_W-1:0] w;
		w = {MAGIC_BASE, BYTE_W'($urandom_range(0, MAGIC_TYPES - 1))};
		for (int i = 0; i < count; i++)
			send_byte(w[i*BYTE_W +: BYTE_W]);
		send_byte(FILLER_BYTE);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (frame_outputs_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_MAX_DATA:    cfg_max = val;
			CFG_META_AUDIO:  req_meta[TYPE_AUDIO] = val[META_REG_W-1:0];
			CFG_META_VIDEO:  req_meta[TYPE_VIDEO] = val[META_REG_W-1:0];
			CFG_META_SUBTTL: req_meta[TYPE_SUBTITLE] = val[META_REG_W-1:0];
			CFG_META_SUBPIC: req_meta[TYPE_SUBPICTURE] = val[META_REG_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// upper bits of the 16-bit registers get random junk that must be dropped
	task automatic set_config(input logic [WORD_W-1:0] max_len,
		input logic [META_REG_W-1:0] audio, input logic [META_REG_W-1:0] video,
		input logic [META_REG_W-1:0] subtitle, input logic [META_REG_W-1:0] subpic);
		write_reg(CFG_MAX_DATA, max_len);
		write_reg(CFG_META_AUDIO, {META_REG_W'($urandom), audio});
		write_reg(CFG_META_VIDEO, {META_REG_W'($urandom), video});
		write_reg(CFG_META_SUBTTL, {META_REG_W'($urandom), subtitle});
		write_reg(CFG_META_SUBPIC, {META_REG_W'($urandom), subpic});
	endtask

	always @(posedge clk) begin : check_results
		frame_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frame_outputs_due.size() == 0) begin
				report_error("result with nothing expected", '0, out_byte);
			end else begin
				want = frame_outputs_due.pop_front();
				if (out_byte !== want.data)
					report_error("out_byte", want.data, out_byte);
				if (out_kind !== want.kind)
					report_error("out_kind", want.kind, out_kind);
				if (frame_type !== want.ftype)
					report_error("frame_type", want.ftype, frame_type);
				if (frame_last !== want.last)
					report_error("frame_last", want.last, frame_last);
			end
		end
	end

	initial begin : receiver
		int run;
		int r;
		forever begin
			if (stall_request > 0) begin
				run = stall_request;
				stall_request = 0;
				out_ready <= 1'b0;
				holding = 1'b1;
				repeat (run) @(posedge clk);
				holding = 1'b0;
			end else if (recv_quiet) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					out_ready <= 1'b1;
					run = $urandom_range(1, 8);
				end else if (r < 92) begin
					out_ready <= 1'b0;
					run = $urandom_range(1, 3);
				end else begin
					out_ready <= 1'b0;
					run = $urandom_range(10, 50);
				end
				repeat (run) @(posedge clk);
			end
		end
	end

	task automatic test_plain_and_typed();
		send_frame(TYPE_PLAIN, '0, 0);
		send_frame(TYPE_PLAIN, '0, 1);
		send_frame(TYPE_PLAIN, '0, 5);
		for (int t = TYPE_AUDIO; t <= TYPE_SUBPICTURE; t++)
			send_frame(TYPE_W'(t), '0, t);
		send_frame(TYPE_VIDEO, '0, 0);
		send_frame(TYPE_AUDIO, 1, 2);
		send_frame(TYPE_PLAIN, '0, DEFAULT_MAX_DATA + 1);
	endtask

	task automatic test_sync_hunting();
		repeat (6) send_byte(BYTE_W'($urandom));
		send_byte(FILLER_BYTE);
		send_frame(TYPE_PLAIN, '0, 3);
		for (int k = 1; k < WORD_W / BYTE_W; k++) begin
			send_partial_magic(k);
			send_frame(TYPE_AUDIO, '0, 2);
		end
		// unknown frame types must not start a header
		for (int t = MAGIC_TYPES; t < 8; t++) begin
			send_word({MAGIC_BASE, BYTE_W'(t)});
			send_byte(FILLER_BYTE);
		end
		send_word({MAGIC_BASE, 8'hff});
		send_byte(FILLER_BYTE);
		send_frame(TYPE_SUBPICTURE, '0, 1);
		// window starts empty after a frame: three magic bytes are not enough
		send_frame(TYPE_PLAIN, '0, 2);
		send_byte(MAGIC_BASE[7:0]);
		send_byte(MAGIC_BASE[15:8]);
		send_byte(MAGIC_BASE[23:16]);
		send_byte(FILLER_BYTE);
		send_frame(TYPE_SUBTITLE, '0, 1);
		// header fields shaped like a magic word are not hunted again
		send_frame(TYPE_PLAIN, '0, {MAGIC_BASE, BYTE_W'(TYPE_PLAIN)});
		send_frame(TYPE_VIDEO, {MAGIC_BASE, BYTE_W'(TYPE_VIDEO)}, 0);
		send_frame(TYPE_PLAIN, '0, 1);
	endtask

	task automatic test_length_checks();
		wait_for_results();
		set_config(6, 3, 0, 1, 2);
		send_frame(TYPE_AUDIO, 3, 6);
		send_frame(TYPE_AUDIO, 3, 7);
		send_frame(TYPE_AUDIO, 2, 1);
		send_frame(TYPE_AUDIO, 32'h0001_0003, 1);
		send_frame(TYPE_PLAIN, '0, 7);
		send_frame(TYPE_PLAIN, '0, 6);
		send_frame(TYPE_VIDEO, '0, 0);
		send_frame(TYPE_SUBTITLE, 1, 0);
		send_frame(TYPE_SUBPICTURE, 2, '1);
		send_frame(TYPE_SUBPICTURE, 2, 4);
		send_frame(TYPE_SUBPICTURE, '0, 0);
	endtask

	task automatic test_register_extremes();
		wait_for_results();
		set_config('0, '1, '0, '1, 1);
		send_frame(TYPE_PLAIN, '0, 0);
		send_frame(TYPE_PLAIN, '0, 1);
		send_frame(TYPE_SUBPICTURE, 1, 0);
		send_frame(TYPE_SUBPICTURE, 1, 1);
		send_frame(TYPE_AUDIO, 32'h0000_fffe, 0);
		send_frame(TYPE_AUDIO, 32'h0001_ffff, 0);
		send_frame(TYPE_AUDIO, '1, 0);
		send_frame(TYPE_VIDEO, '0, 0);
		wait_for_results();
		// writes past the last register index change nothing
		for (int i = int'(CFG_META_SUBPIC) + 1; i < (1 << CFG_IDX_W); i++)
			write_reg(CFG_IDX_W'(i), $urandom);
		send_frame(TYPE_PLAIN, '0, 1);
		send_frame(TYPE_VIDEO, '0, 0);
		wait_for_results();
		write_reg(CFG_MAX_DATA, '1);
		send_frame(TYPE_PLAIN, '0, 9);
		send_frame(TYPE_SUBPICTURE, 1, 3);
	endtask

	task automatic test_long_metadata();
		wait_for_results();
		set_config('1, '0, '0, META_REG_W'(LONG_META), '0);
		send_quiet = 1'b1;
		recv_quiet = 1'b1;
		send_frame(TYPE_SUBTITLE, WORD_W'(LONG_META), 2);
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
	endtask

	task automatic test_backpressure();
		wait_for_results();
		set_config(DEFAULT_MAX_DATA, 0, 0, 0, 0);
		stall_request = LONG_HOLD;
		wait (holding);
		send_quiet = 1'b1;
		send_frame(TYPE_PLAIN, '0, 80);
		send_quiet = 1'b0;
		// sender sits idle until the block has handed everything out
		wait_for_results();
		send_frame(TYPE_VIDEO, '0, 3);
	endtask

	task automatic pick_random_config();
		int                r;
		logic [WORD_W-1:0] max_len;
		r = $urandom_range(0, 9);
		if (r == 0)
			max_len = '0;
		else if (r == 1)
			max_len = '1;
		else if (r == 2)
			max_len = DEFAULT_MAX_DATA;
		else
			max_len = $urandom_range(0, 12);
		set_config(max_len, $urandom_range(0, 5), $urandom_range(0, 5),
			$urandom_range(0, 5), $urandom_range(0, 5));
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(int'(CFG_META_SUBPIC) + 1,
				(1 << CFG_IDX_W) - 1)), $urandom);
	endtask

	task automatic test_random_frames();
		int                start;
		int                frames;
		int                r;
		logic [TYPE_W-1:0] t;
		logic [WORD_W-1:0] meta;
		logic [WORD_W-1:0] len;
		start = bytes_sent;
		frames = 0;
		while (bytes_sent - start < RANDOM_BYTES) begin
			if (frames % 30 == 0) begin
				wait_for_results();
				pick_random_config();
			end
			frames++;
			send_quiet = ($urandom_range(0, 9) < 2);
			recv_quiet = ($urandom_range(0, 9) < 2);
			r = $urandom_range(0, 99);
			if (r < 80) begin
				t = $urandom_range(0, MAGIC_TYPES - 1);
				meta = meta_required(t);
				if ($urandom_range(0, 99) < 12)
					meta = meta ^ (32'd1 << $urandom_range(0, WORD_W - 1));
				r = $urandom_range(0, 99);
				if (r < 15) begin
					len = 0;
				end else if (r < 88) begin
					len = $urandom_range(0, 12);
				end else begin
					// long lengths only where they get rejected
					len = $urandom;
					if (len <= cfg_max)
						len = (cfg_max == '1) ? $urandom_range(0, 12) : cfg_max + 1;
				end
				send_frame(t, meta, len);
			end else begin
				case ($urandom_range(0, 3))
					0: repeat ($urandom_range(1, 8)) send_byte(BYTE_W'($urandom));
					1: send_partial_magic($urandom_range(1, 3));
					2: send_word({MAGIC_BASE, BYTE_W'($urandom_range(MAGIC_TYPES, 255))});
					default: repeat ($urandom_range(1, 6))
						send_byte($urandom_range(0, 1) ? 8'h00 : 8'hff);
				endcase
				send_byte(FILLER_BYTE);
			end
		end
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_and_typed();
		test_sync_hunting();
		test_length_checks();
		test_register_extremes();
		test_long_metadata();
		test_backpressure();
		test_random_frames();
		wait_for_results();
		if (error_count == 0)
			$display("magic_word_length_deframer_core: match");
		else
			$display("magic_word_length_deframer_core: mismatch");
		$finish;
	end

endmodule
